@@ hw/rtl/hls_pkg.sv @@
// ----------------------------------------------------------------------------
// hls_pkg: shared definitions for the header layer stack
// Sizes, entry and result layouts, operation and status codes, and the
// sequencer states used by the control module.
// ----------------------------------------------------------------------------
package hls_pkg;

    localparam int MAX_LAYERS  = 16;
    localparam int PROTO_COUNT = 32;
    localparam int OFFSET_BITS = 16;

    localparam int IDX_W   = $clog2(MAX_LAYERS);
    localparam int CNT_W   = $clog2(MAX_LAYERS + 1);
    localparam int POS_W   = 5;
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int OP_W    = 3;
    localparam int PROTO_W = 5;
    localparam int KIND_W  = 4;
    localparam int MASK_W  = 32;
    localparam int LEN_W   = 16;
    localparam int SUM_W   = ((OFFSET_BITS > LEN_W) ? OFFSET_BITS : LEN_W) + 1;

    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 56;

    localparam logic [OP_W-1:0] OP_FIND_FIRST = 3'd0;
    localparam logic [OP_W-1:0] OP_FIND_LAST  = 3'd1;
    localparam logic [OP_W-1:0] OP_MASK_FIRST = 3'd2;
    localparam logic [OP_W-1:0] OP_MASK_LAST  = 3'd3;
    localparam logic [OP_W-1:0] OP_PUSH       = 3'd4;
    localparam logic [OP_W-1:0] OP_POP        = 3'd5;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_BAD_INDEX = 3'd2,
        ST_FULL      = 3'd3,
        ST_OVERFLOW  = 3'd4
    } status_t;

    typedef struct packed {
        logic [PROTO_W-1:0]     proto;
        logic [KIND_W-1:0]      kind;
        logic [OFFSET_BITS-1:0] offset;
        logic [LEN_W-1:0]       length;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [POS_W-1:0]   position;
        logic [PROTO_W-1:0] proto_id;
        logic [KIND_W-1:0]  proto_kind;
        logic [MASK_W-1:0]  proto_mask;
        logic [LEN_W-1:0]   layer_length;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic        found;
        logic [3:0]  result_index;
        logic [4:0]  stack_depth_out;
        logic [4:0]  entry_proto;
        logic [3:0]  entry_kind;
        logic [15:0] entry_offset;
        logic [15:0] entry_length;
    } out_result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_TAIL_RD,
        S_TAIL_CHK,
        S_CHK_RD,
        S_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FRESH_WR,
        S_POP_RD0,
        S_POP_GONE,
        S_POP_RD,
        S_POP_WR,
        S_EMIT
    } state_t;

endpackage

@@ hw/rtl/hls_ram.sv @@
// ----------------------------------------------------------------------------
// hls_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// ----------------------------------------------------------------------------
module hls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/hls_out.sv @@
// ----------------------------------------------------------------------------
// hls_out: result output register
// Holds one finished result for the master side and packs it into tdata.
// ----------------------------------------------------------------------------
module hls_out (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             load,
    input  hls_pkg::out_result_t             result,
    output logic                             free,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [hls_pkg::M_DATA_W-1:0]     m_tdata
);

    logic                 valid_reg;
    logic                 valid_next;
    hls_pkg::out_result_t data_reg;

    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00,
                       data_reg.entry_length,
                       data_reg.entry_offset,
                       data_reg.entry_kind,
                       data_reg.entry_proto,
                       data_reg.stack_depth_out,
                       data_reg.result_index,
                       data_reg.found,
                       data_reg.status};

endmodule

@@ hw/rtl/hls_ctrl.sv @@
// ----------------------------------------------------------------------------
// hls_ctrl: stack sequencer
// Walks the entry memory one entry at a time for searches, offset checks
// and the shifts of push and pop, and builds the result of each beat.
// ----------------------------------------------------------------------------
module hls_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  hls_pkg::in_item_t             in_item,
    input  logic                          out_free,
    output logic                          out_load,
    output hls_pkg::out_result_t          out_result,
    output logic                          ram_we,
    output logic [hls_pkg::IDX_W-1:0]     ram_waddr,
    output logic [hls_pkg::ENTRY_W-1:0]   ram_wdata,
    output logic [hls_pkg::IDX_W-1:0]     ram_raddr,
    input  logic [hls_pkg::ENTRY_W-1:0]   ram_rdata
);

    hls_pkg::state_t                  state_reg, state_next;
    logic [hls_pkg::OP_W-1:0]         op_reg, op_next;
    logic [hls_pkg::POS_W-1:0]        pos_reg, pos_next;
    logic [hls_pkg::PROTO_W-1:0]      id_reg, id_next;
    logic [hls_pkg::KIND_W-1:0]       kind_reg, kind_next;
    logic [hls_pkg::MASK_W-1:0]       mask_reg, mask_next;
    logic [hls_pkg::LEN_W-1:0]        len_reg, len_next;
    logic [hls_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [hls_pkg::CNT_W-1:0]        cur_reg, cur_next;
    logic [hls_pkg::CNT_W-1:0]        rem_reg, rem_next;
    logic [hls_pkg::OFFSET_BITS-1:0]  start_reg, start_next;
    logic [hls_pkg::LEN_W-1:0]        gone_len_reg, gone_len_next;
    hls_pkg::out_result_t             res_reg, res_next;

    hls_pkg::entry_t                  rd_entry;
    hls_pkg::entry_t                  fresh;
    logic [hls_pkg::CMP_W-1:0]        pos_ext;
    logic [hls_pkg::CMP_W-1:0]        cnt_ext;
    logic [hls_pkg::CNT_W-1:0]        cur_inc;
    logic [hls_pkg::CNT_W-1:0]        cur_dec;
    logic [hls_pkg::CNT_W-1:0]        cnt_dec;
    logic                             is_search;
    logic                             is_last;
    logic                             use_mask;
    logic                             hit;
    logic [hls_pkg::SUM_W-1:0]        shift_sum;
    logic [hls_pkg::SUM_W-1:0]        tail_sum;
    logic [hls_pkg::SUM_W-1:0]        pop_diff;
    logic                             shift_ovf;
    logic                             tail_ovf;
    logic                             pop_keep;

    function automatic hls_pkg::out_result_t make_result(
        hls_pkg::status_t           status,
        logic                       found,
        logic [hls_pkg::IDX_W-1:0]  idx,
        hls_pkg::entry_t            e
    );
        hls_pkg::out_result_t r;
        r.status          = status;
        r.found           = found;
        r.result_index    = 4'(idx);
        r.stack_depth_out = '0;
        r.entry_proto     = e.proto;
        r.entry_kind      = e.kind;
        r.entry_offset    = 16'(e.offset);
        r.entry_length    = e.length;
        return r;
    endfunction

    function automatic hls_pkg::out_result_t fail_result(hls_pkg::status_t status);
        hls_pkg::out_result_t r;
        r        = '0;
        r.status = status;
        return r;
    endfunction

    assign rd_entry  = hls_pkg::entry_t'(ram_rdata);
    assign pos_ext   = hls_pkg::CMP_W'(pos_reg);
    assign cnt_ext   = hls_pkg::CMP_W'(count_reg);
    assign cur_inc   = cur_reg + 1'b1;
    assign cur_dec   = cur_reg - 1'b1;
    assign cnt_dec   = count_reg - 1'b1;

    assign is_search = (op_reg == hls_pkg::OP_FIND_FIRST) || (op_reg == hls_pkg::OP_FIND_LAST)
                    || (op_reg == hls_pkg::OP_MASK_FIRST) || (op_reg == hls_pkg::OP_MASK_LAST);
    assign is_last   = (op_reg == hls_pkg::OP_FIND_LAST) || (op_reg == hls_pkg::OP_MASK_LAST);
    assign use_mask  = (op_reg == hls_pkg::OP_MASK_FIRST) || (op_reg == hls_pkg::OP_MASK_LAST);

    // Mask bits above the protocol range never match.
    assign hit = use_mask
               ? ((32'(rd_entry.proto) < hls_pkg::PROTO_COUNT) && mask_reg[rd_entry.proto])
               : (rd_entry.proto == id_reg);

    assign shift_sum = hls_pkg::SUM_W'(rd_entry.offset) + hls_pkg::SUM_W'(len_reg);
    assign tail_sum  = hls_pkg::SUM_W'(rd_entry.offset) + hls_pkg::SUM_W'(rd_entry.length);
    assign pop_diff  = hls_pkg::SUM_W'(rd_entry.offset) - hls_pkg::SUM_W'(gone_len_reg);
    assign shift_ovf = |shift_sum[hls_pkg::SUM_W-1:hls_pkg::OFFSET_BITS];
    assign tail_ovf  = |tail_sum[hls_pkg::SUM_W-1:hls_pkg::OFFSET_BITS];
    assign pop_keep  = hls_pkg::SUM_W'(rd_entry.offset) >= hls_pkg::SUM_W'(gone_len_reg);

    always_comb
    begin
        fresh.proto  = id_reg;
        fresh.kind   = kind_reg;
        fresh.offset = start_reg;
        fresh.length = len_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hls_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = hls_pkg::S_DECODE;
                end
            end
            hls_pkg::S_DECODE:
            begin
                if (is_search)
                begin
                    state_next = (count_reg == '0) ? hls_pkg::S_EMIT : hls_pkg::S_SRCH_RD;
                end
                else if (op_reg == hls_pkg::OP_PUSH)
                begin
                    if (pos_ext > cnt_ext || 32'(count_reg) >= hls_pkg::MAX_LAYERS)
                    begin
                        state_next = hls_pkg::S_EMIT;
                    end
                    else if (pos_ext == cnt_ext)
                    begin
                        state_next = (count_reg == '0) ? hls_pkg::S_FRESH_WR : hls_pkg::S_TAIL_RD;
                    end
                    else
                    begin
                        state_next = hls_pkg::S_CHK_RD;
                    end
                end
                else if (op_reg == hls_pkg::OP_POP)
                begin
                    state_next = (pos_ext >= cnt_ext) ? hls_pkg::S_EMIT : hls_pkg::S_POP_RD0;
                end
                else
                begin
                    state_next = hls_pkg::S_EMIT;
                end
            end
            hls_pkg::S_SRCH_RD:
            begin
                state_next = hls_pkg::S_SRCH_CHK;
            end
            hls_pkg::S_SRCH_CHK:
            begin
                if (hit || rem_reg == hls_pkg::CNT_W'(1))
                begin
                    state_next = hls_pkg::S_EMIT;
                end
                else
                begin
                    state_next = hls_pkg::S_SRCH_RD;
                end
            end
            hls_pkg::S_TAIL_RD:
            begin
                state_next = hls_pkg::S_TAIL_CHK;
            end
            hls_pkg::S_TAIL_CHK:
            begin
                state_next = tail_ovf ? hls_pkg::S_EMIT : hls_pkg::S_FRESH_WR;
            end
            hls_pkg::S_CHK_RD:
            begin
                state_next = hls_pkg::S_CHK;
            end
            hls_pkg::S_CHK:
            begin
                if (shift_ovf)
                begin
                    state_next = hls_pkg::S_EMIT;
                end
                else if (cur_inc == count_reg)
                begin
                    state_next = hls_pkg::S_SHIFT_RD;
                end
                else
                begin
                    state_next = hls_pkg::S_CHK_RD;
                end
            end
            hls_pkg::S_SHIFT_RD:
            begin
                state_next = hls_pkg::S_SHIFT_WR;
            end
            hls_pkg::S_SHIFT_WR:
            begin
                if (hls_pkg::CMP_W'(cur_dec) == pos_ext)
                begin
                    state_next = hls_pkg::S_FRESH_WR;
                end
                else
                begin
                    state_next = hls_pkg::S_SHIFT_RD;
                end
            end
            hls_pkg::S_FRESH_WR:
            begin
                state_next = hls_pkg::S_EMIT;
            end
            hls_pkg::S_POP_RD0:
            begin
                state_next = hls_pkg::S_POP_GONE;
            end
            hls_pkg::S_POP_GONE:
            begin
                if (pos_ext == hls_pkg::CMP_W'(cnt_dec))
                begin
                    state_next = hls_pkg::S_EMIT;
                end
                else
                begin
                    state_next = hls_pkg::S_POP_RD;
                end
            end
            hls_pkg::S_POP_RD:
            begin
                state_next = hls_pkg::S_POP_WR;
            end
            hls_pkg::S_POP_WR:
            begin
                state_next = (cur_inc == count_reg) ? hls_pkg::S_EMIT : hls_pkg::S_POP_RD;
            end
            hls_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = hls_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = hls_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        op_next       = op_reg;
        pos_next      = pos_reg;
        id_next       = id_reg;
        kind_next     = kind_reg;
        mask_next     = mask_reg;
        len_next      = len_reg;
        count_next    = count_reg;
        cur_next      = cur_reg;
        rem_next      = rem_reg;
        start_next    = start_reg;
        gone_len_next = gone_len_reg;
        res_next      = res_reg;
        in_ready      = 1'b0;
        out_load      = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = cur_reg[hls_pkg::IDX_W-1:0];
        ram_wdata     = '0;
        ram_raddr     = cur_reg[hls_pkg::IDX_W-1:0];

        unique case (state_reg)
            hls_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next   = in_item.op;
                    pos_next  = in_item.position;
                    id_next   = in_item.proto_id;
                    kind_next = in_item.proto_kind;
                    mask_next = in_item.proto_mask;
                    len_next  = in_item.layer_length;
                end
            end
            hls_pkg::S_DECODE:
            begin
                if (is_search)
                begin
                    rem_next = count_reg;
                    cur_next = is_last ? cnt_dec : '0;
                    if (count_reg == '0)
                    begin
                        res_next = fail_result(hls_pkg::ST_NOT_FOUND);
                    end
                end
                else if (op_reg == hls_pkg::OP_PUSH)
                begin
                    start_next = '0;
                    cur_next   = hls_pkg::CNT_W'(pos_reg);
                    if (pos_ext > cnt_ext)
                    begin
                        res_next = fail_result(hls_pkg::ST_BAD_INDEX);
                    end
                    else if (32'(count_reg) >= hls_pkg::MAX_LAYERS)
                    begin
                        res_next = fail_result(hls_pkg::ST_FULL);
                    end
                end
                else if (op_reg == hls_pkg::OP_POP)
                begin
                    if (pos_ext >= cnt_ext)
                    begin
                        res_next = fail_result(hls_pkg::ST_BAD_INDEX);
                    end
                end
                else
                begin
                    res_next = fail_result(hls_pkg::ST_BAD_INDEX);
                end
            end
            hls_pkg::S_SRCH_RD:
            begin
                ram_raddr = cur_reg[hls_pkg::IDX_W-1:0];
            end
            hls_pkg::S_SRCH_CHK:
            begin
                if (hit)
                begin
                    res_next = make_result(hls_pkg::ST_OK, 1'b1,
                                           cur_reg[hls_pkg::IDX_W-1:0], rd_entry);
                end
                else if (rem_reg == hls_pkg::CNT_W'(1))
                begin
                    res_next = fail_result(hls_pkg::ST_NOT_FOUND);
                end
                else
                begin
                    rem_next = rem_reg - 1'b1;
                    cur_next = is_last ? cur_dec : cur_inc;
                end
            end
            hls_pkg::S_TAIL_RD:
            begin
                ram_raddr = cnt_dec[hls_pkg::IDX_W-1:0];
            end
            hls_pkg::S_TAIL_CHK:
            begin
                if (tail_ovf)
                begin
                    res_next = fail_result(hls_pkg::ST_OVERFLOW);
                end
                else
                begin
                    start_next = tail_sum[hls_pkg::OFFSET_BITS-1:0];
                end
            end
            hls_pkg::S_CHK_RD:
            begin
                ram_raddr = cur_reg[hls_pkg::IDX_W-1:0];
            end
            hls_pkg::S_CHK:
            begin
                // The entry being displaced gives the new entry its offset.
                if (hls_pkg::CMP_W'(cur_reg) == pos_ext)
                begin
                    start_next = rd_entry.offset;
                end
                if (shift_ovf)
                begin
                    res_next = fail_result(hls_pkg::ST_OVERFLOW);
                end
                else
                begin
                    cur_next = cur_inc;
                end
            end
            hls_pkg::S_SHIFT_RD:
            begin
                ram_raddr = cur_dec[hls_pkg::IDX_W-1:0];
            end
            hls_pkg::S_SHIFT_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cur_reg[hls_pkg::IDX_W-1:0];
                ram_wdata = {rd_entry.proto, rd_entry.kind,
                             shift_sum[hls_pkg::OFFSET_BITS-1:0], rd_entry.length};
                cur_next  = cur_dec;
            end
            hls_pkg::S_FRESH_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = hls_pkg::IDX_W'(pos_reg);
                ram_wdata  = fresh;
                count_next = count_reg + 1'b1;
                res_next   = make_result(hls_pkg::ST_OK, 1'b0, hls_pkg::IDX_W'(pos_reg), fresh);
            end
            hls_pkg::S_POP_RD0:
            begin
                ram_raddr = hls_pkg::IDX_W'(pos_reg);
            end
            hls_pkg::S_POP_GONE:
            begin
                res_next      = make_result(hls_pkg::ST_OK, 1'b0, hls_pkg::IDX_W'(pos_reg),
                                            rd_entry);
                gone_len_next = rd_entry.length;
                count_next    = cnt_dec;
                cur_next      = hls_pkg::CNT_W'(pos_reg);
            end
            hls_pkg::S_POP_RD:
            begin
                ram_raddr = cur_inc[hls_pkg::IDX_W-1:0];
            end
            hls_pkg::S_POP_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cur_reg[hls_pkg::IDX_W-1:0];
                ram_wdata = {rd_entry.proto, rd_entry.kind,
                             pop_keep ? pop_diff[hls_pkg::OFFSET_BITS-1:0] : '0,
                             rd_entry.length};
                cur_next  = cur_inc;
            end
            hls_pkg::S_EMIT:
            begin
                out_load = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_result                 = res_reg;
        out_result.stack_depth_out = 5'(count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hls_pkg::S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        pos_reg      <= pos_next;
        id_reg       <= id_next;
        kind_reg     <= kind_next;
        mask_reg     <= mask_next;
        len_reg      <= len_next;
        cur_reg      <= cur_next;
        rem_reg      <= rem_next;
        start_reg    <= start_next;
        gone_len_reg <= gone_len_next;
        res_reg      <= res_next;
    end

endmodule

@@ hw/rtl/header_layer_stack.sv @@
// One beat at a time: the next beat is taken in the cycle after the result is
//   loaded into the output register, even while that result still waits to be taken.
// The entry memory has a single read port and is walked one entry at a time: each
//   entry is read in one state and checked or written back in the next.
// A search stops at its first hit, else after every entry below the depth.
// Reset clears the depth and the handshakes only; the entry memory has no clearing pass.
// ----------------------------------------------------------------------------
// header_layer_stack: ordered stack of packet header layers
// Keeps up to MAX_LAYERS entries of protocol, kind, offset and length in a
// synchronous RAM and performs searches, pushes and pops on them.
// ----------------------------------------------------------------------------
module header_layer_stack (
    input  logic                              clk,
    input  logic                              rst_n,
    // Slave side: one operation per beat.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata from bit 0: position[4:0], proto_id[9:5], proto_kind[13:10],
    // proto_mask[45:14], layer_length[61:46], zero padding[63:62]
    input  logic [hls_pkg::S_DATA_W-1:0]      s_tdata,
    // tuser: op[2:0]
    input  logic [hls_pkg::OP_W-1:0]          s_tuser,
    // Master side: one result per operation.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata from bit 0: status[2:0], found[3], result_index[7:4],
    // stack_depth_out[12:8], entry_proto[17:13], entry_kind[21:18],
    // entry_offset[37:22], entry_length[53:38], zero padding[55:54]
    output logic [hls_pkg::M_DATA_W-1:0]      m_tdata
);

    hls_pkg::in_item_t                in_item;
    hls_pkg::out_result_t             result;
    logic                             out_free;
    logic                             out_load;
    logic                             ram_we;
    logic [hls_pkg::IDX_W-1:0]        ram_waddr;
    logic [hls_pkg::ENTRY_W-1:0]      ram_wdata;
    logic [hls_pkg::IDX_W-1:0]        ram_raddr;
    logic [hls_pkg::ENTRY_W-1:0]      ram_rdata;

    // Unpack the slave beat; the top two bits of tdata are padding.
    always_comb
    begin
        in_item.op           = s_tuser;
        in_item.position     = s_tdata[4:0];
        in_item.proto_id     = s_tdata[9:5];
        in_item.proto_kind   = s_tdata[13:10];
        in_item.proto_mask   = s_tdata[45:14];
        in_item.layer_length = s_tdata[61:46];
    end

    // The sequencer owns the depth counter and walks the memory entry by
    // entry, reading in one cycle and checking or writing back in the next,
    // so no read whose data is used ever meets a write to the same entry.
    hls_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .out_free   (out_free),
        .out_load   (out_load),
        .out_result (result),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    // Entry store: contents are undefined until written, but only entries
    // below the current depth are ever used.
    hls_ram #(
        .WIDTH (hls_pkg::ENTRY_W),
        .DEPTH (hls_pkg::MAX_LAYERS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register decouples the master side from the sequencer.
    hls_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (out_load),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
